// ===== sv/stc_pkg.sv =====
package stc_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 16;
   localparam int unsigned QUEUE_DEPTH    = 2;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_XFER = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // opcodes
   localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
   localparam logic [7:0] OP_REZERO          = 8'h01;
   localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
   localparam logic [7:0] OP_FORMAT          = 8'h04;
   localparam logic [7:0] OP_READ6           = 8'h08;
   localparam logic [7:0] OP_WRITE6          = 8'h0A;
   localparam logic [7:0] OP_SEEK6           = 8'h0B;
   localparam logic [7:0] OP_INQUIRY         = 8'h12;
   localparam logic [7:0] OP_MODE_SELECT     = 8'h15;
   localparam logic [7:0] OP_MODE_SENSE      = 8'h1A;
   localparam logic [7:0] OP_START_STOP      = 8'h1B;
   localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
   localparam logic [7:0] OP_READ10          = 8'h28;
   localparam logic [7:0] OP_WRITE10         = 8'h2A;
   localparam logic [7:0] OP_SEEK10          = 8'h2B;

   // sense keys and additional sense codes
   localparam logic [3:0] KEY_NONE      = 4'h0;
   localparam logic [3:0] KEY_NOT_READY = 4'h2;
   localparam logic [3:0] KEY_ILLEGAL   = 4'h5;
   localparam logic [7:0] ASC_NONE      = 8'h00;
   localparam logic [7:0] ASC_NO_MEDIUM = 8'h3A;
   localparam logic [7:0] ASC_LBA_RANGE = 8'h21;
   localparam logic [7:0] ASC_BAD_OP    = 8'h20;
   localparam logic [7:0] ASC_READ_ERR  = 8'h11;
   localparam logic [7:0] ASC_WRITE_ERR = 8'h0C;

   // response lengths
   localparam logic [5:0] LEN_SENSE    = 6'd18;
   localparam logic [5:0] LEN_INQUIRY  = 6'd36;
   localparam logic [5:0] LEN_MODE     = 6'd4;
   localparam logic [5:0] LEN_CAPACITY = 6'd8;

   typedef struct packed {
      logic       operation;
      logic       transfer_ok;
      logic [7:0] cdb_opcode;
      logic [7:0] cdb_byte1;
      logic [7:0] cdb_byte2;
      logic [7:0] cdb_byte3;
      logic [7:0] cdb_byte4;
      logic [7:0] cdb_byte5;
      logic [7:0] cdb_byte7;
      logic [7:0] cdb_byte8;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        status;
      logic [31:0] transfer_lba;
      logic [4:0]  transfer_blocks;
      logic        transfer_write;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ACT_REPORT,
      ACT_STREAM,
      ACT_XFER,
      ACT_DONE
   } act_type;

   typedef enum logic [1:0] {
      TBL_SENSE,
      TBL_INQUIRY,
      TBL_MODE,
      TBL_CAPACITY
   } tbl_type;

   // one classified command, front to back
   typedef struct packed {
      act_type     act;
      tbl_type     tbl;
      logic [5:0]  nbytes;
      logic        ok;
      logic        status;
      logic [3:0]  key;
      logic [7:0]  code;
      logic [31:0] lba;
      logic [4:0]  blocks;
      logic        wr;
   } job_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

   function automatic logic [7:0] inquiry_byte(input logic [5:0] idx);
      logic [7:0] b;
      case (idx)
         6'd2, 6'd3: b = 8'h01;
         6'd4:       b = 8'h1F;
         6'd8:       b = 8'h4E;
         6'd9:       b = 8'h45;
         6'd10:      b = 8'h43;
         6'd16:      b = 8'h50;
         6'd17:      b = 8'h43;
         6'd18:      b = 8'h2D;
         6'd19:      b = 8'h39;
         6'd20:      b = 8'h38;
         6'd22:      b = 8'h48;
         6'd23, 6'd24: b = 8'h44;
         6'd32:      b = 8'h31;
         6'd33:      b = 8'h2E;
         6'd34, 6'd35: b = 8'h30;
         6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd21,
         6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31: b = 8'h20;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] resp_byte(input tbl_type tbl, input logic [5:0] idx,
                                            input logic [3:0] key, input logic [7:0] code,
                                            input logic [31:0] last_lba);
      logic [7:0] b;
      b = 8'h00;
      case (tbl)
         TBL_SENSE: begin
            case (idx)
               6'd0:    b = 8'h70;
               6'd2:    b = {4'h0, key};
               6'd7:    b = 8'd10;
               6'd12:   b = code;
               default: b = 8'h00;
            endcase
         end
         TBL_INQUIRY: b = inquiry_byte(idx);
         TBL_MODE:    b = (idx == 6'd0) ? 8'h03 : 8'h00;
         default: begin
            case (idx)
               6'd0:    b = last_lba[31:24];
               6'd1:    b = last_lba[23:16];
               6'd2:    b = last_lba[15:8];
               6'd3:    b = last_lba[7:0];
               6'd6:    b = 8'h02;
               default: b = 8'h00;
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// ===== sv/stc_front.sv =====
module stc_front #(
   parameter int unsigned MAX_BLOCKS = stc_pkg::MAX_BLOCKS_DEF
) (
   input  stc_pkg::req_type req,
   input  logic [31:0]      disk_sectors,
   output stc_pkg::job_type job
);

   logic        no_medium;
   logic        is_rw;
   logic [15:0] count;
   logic [31:0] rw_lba;
   logic [4:0]  clamped;
   logic [32:0] end_lba;
   logic        out_of_range;
   logic [5:0]  len;
   logic [5:0]  alloc_len;

   assign no_medium = (disk_sectors == 32'd0);

   always_comb begin
      is_rw  = 1'b0;
      count  = 16'd0;
      rw_lba = 32'd0;
      len    = stc_pkg::LEN_SENSE;
      job    = '0;
      job.act    = stc_pkg::ACT_DONE;
      job.tbl    = stc_pkg::TBL_SENSE;
      job.ok     = req.transfer_ok;
      job.key    = stc_pkg::KEY_NONE;
      job.code   = stc_pkg::ASC_NONE;

      unique case (req.cdb_opcode) inside
         stc_pkg::OP_READ6, stc_pkg::OP_WRITE6: begin
            is_rw  = 1'b1;
            rw_lba = {11'd0, req.cdb_byte1[4:0], req.cdb_byte2, req.cdb_byte3};
            count  = (req.cdb_byte4 == 8'd0) ? 16'd256 : {8'd0, req.cdb_byte4};
         end
         stc_pkg::OP_READ10, stc_pkg::OP_WRITE10: begin
            is_rw  = 1'b1;
            rw_lba = {req.cdb_byte2, req.cdb_byte3, req.cdb_byte4, req.cdb_byte5};
            count  = {req.cdb_byte7, req.cdb_byte8};
         end
         default: begin
            is_rw = 1'b0;
         end
      endcase

      // clamp and range check, 33 bits wide
      clamped = (count > 16'(MAX_BLOCKS)) ? 5'(MAX_BLOCKS) : count[4:0];
      end_lba = {1'b0, rw_lba} + {28'd0, clamped};
      out_of_range = (rw_lba >= disk_sectors) || (end_lba > {1'b0, disk_sectors});

      unique case (req.cdb_opcode)
         stc_pkg::OP_REQUEST_SENSE: len = stc_pkg::LEN_SENSE;
         stc_pkg::OP_INQUIRY:       len = stc_pkg::LEN_INQUIRY;
         stc_pkg::OP_MODE_SENSE:    len = stc_pkg::LEN_MODE;
         default:                   len = stc_pkg::LEN_CAPACITY;
      endcase
      alloc_len = (req.cdb_byte4 == 8'd0 || req.cdb_byte4 > {2'b00, len}) ?
                  len : req.cdb_byte4[5:0];

      if (req.operation) begin
         job.act = stc_pkg::ACT_REPORT;
      end else if (is_rw) begin
         job.wr = (req.cdb_opcode == stc_pkg::OP_WRITE6) ||
                  (req.cdb_opcode == stc_pkg::OP_WRITE10);
         if (no_medium) begin
            job.status = 1'b1;
            job.key    = stc_pkg::KEY_NOT_READY;
            job.code   = stc_pkg::ASC_NO_MEDIUM;
         end else if (count == 16'd0) begin
            job.status = 1'b0;
         end else if (out_of_range) begin
            job.status = 1'b1;
            job.key    = stc_pkg::KEY_ILLEGAL;
            job.code   = stc_pkg::ASC_LBA_RANGE;
         end else begin
            job.act    = stc_pkg::ACT_XFER;
            job.lba    = rw_lba;
            job.blocks = clamped;
         end
      end else begin
         unique case (req.cdb_opcode) inside
            stc_pkg::OP_TEST_UNIT_READY: begin
               if (no_medium) begin
                  job.status = 1'b1;
                  job.key    = stc_pkg::KEY_NOT_READY;
                  job.code   = stc_pkg::ASC_NO_MEDIUM;
               end
            end
            stc_pkg::OP_REZERO, stc_pkg::OP_FORMAT, stc_pkg::OP_SEEK6,
            stc_pkg::OP_MODE_SELECT, stc_pkg::OP_START_STOP, stc_pkg::OP_SEEK10: begin
               job.status = 1'b0;
            end
            stc_pkg::OP_REQUEST_SENSE: begin
               job.act    = stc_pkg::ACT_STREAM;
               job.tbl    = stc_pkg::TBL_SENSE;
               job.nbytes = alloc_len;
            end
            stc_pkg::OP_INQUIRY: begin
               job.act    = stc_pkg::ACT_STREAM;
               job.tbl    = stc_pkg::TBL_INQUIRY;
               job.nbytes = alloc_len;
            end
            stc_pkg::OP_MODE_SENSE: begin
               job.act    = stc_pkg::ACT_STREAM;
               job.tbl    = stc_pkg::TBL_MODE;
               job.nbytes = alloc_len;
            end
            stc_pkg::OP_READ_CAPACITY: begin
               if (no_medium) begin
                  job.status = 1'b1;
                  job.key    = stc_pkg::KEY_NOT_READY;
                  job.code   = stc_pkg::ASC_NO_MEDIUM;
               end else begin
                  // carry the last block address in the lba field
                  job.act    = stc_pkg::ACT_STREAM;
                  job.tbl    = stc_pkg::TBL_CAPACITY;
                  job.nbytes = stc_pkg::LEN_CAPACITY;
                  job.lba    = disk_sectors - 32'd1;
               end
            end
            default: begin
               job.status = 1'b1;
               job.key    = stc_pkg::KEY_ILLEGAL;
               job.code   = stc_pkg::ASC_BAD_OP;
            end
         endcase
      end
   end

endmodule

// ===== sv/stc_queue.sv =====
module stc_queue #(
   parameter int unsigned DEPTH = stc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  stc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output stc_pkg::job_type pop_job,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   stc_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/stc_back.sv =====
module stc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  stc_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output stc_pkg::rsp_type rsp_data
);

   stc_pkg::bk_state_type state_ff, state_in;
   stc_pkg::job_type      job_ff, job_in;
   logic [5:0]            idx_ff, idx_in;
   logic [3:0]            key_ff, key_in;
   logic [7:0]            code_ff, code_in;
   logic                  pend_ff, pend_in;
   logic                  pend_wr_ff, pend_wr_in;
   stc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;
   logic                  emit;
   stc_pkg::rsp_type      beat;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_pop;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      code_in    = code_ff;
      pend_in    = pend_ff;
      pend_wr_in = pend_wr_ff;
      job_pop    = 1'b0;
      emit       = 1'b0;
      beat       = '0;
      beat.kind  = stc_pkg::KIND_DONE;
      beat.last  = 1'b1;

      unique case (state_ff)
         stc_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               idx_in   = '0;
               state_in = stc_pkg::BK_RUN;
               // a new command drops any transfer still outstanding
               if (job.act != stc_pkg::ACT_REPORT) begin
                  pend_in = 1'b0;
               end
            end
         end
         stc_pkg::BK_RUN: begin
            if (job_ff.act == stc_pkg::ACT_REPORT && !pend_ff) begin
               state_in = stc_pkg::BK_IDLE;
            end else if (slot_free) begin
               emit = 1'b1;
               case (job_ff.act)
                  stc_pkg::ACT_STREAM: begin
                     if (idx_ff < job_ff.nbytes) begin
                        beat.kind      = stc_pkg::KIND_DATA;
                        beat.last      = 1'b0;
                        beat.data_byte = stc_pkg::resp_byte(job_ff.tbl, idx_ff, key_ff,
                                                            code_ff, job_ff.lba);
                        idx_in         = idx_ff + 6'd1;
                     end else begin
                        key_in   = stc_pkg::KEY_NONE;
                        code_in  = stc_pkg::ASC_NONE;
                        state_in = stc_pkg::BK_IDLE;
                     end
                  end
                  stc_pkg::ACT_XFER: begin
                     beat.kind            = stc_pkg::KIND_XFER;
                     beat.transfer_lba    = job_ff.lba;
                     beat.transfer_blocks = job_ff.blocks;
                     beat.transfer_write  = job_ff.wr;
                     pend_in              = 1'b1;
                     pend_wr_in           = job_ff.wr;
                     state_in             = stc_pkg::BK_IDLE;
                  end
                  stc_pkg::ACT_REPORT: begin
                     pend_in = 1'b0;
                     if (job_ff.ok) begin
                        key_in  = stc_pkg::KEY_NONE;
                        code_in = stc_pkg::ASC_NONE;
                     end else begin
                        beat.status = 1'b1;
                        key_in      = stc_pkg::KEY_NOT_READY;
                        code_in     = pend_wr_ff ? stc_pkg::ASC_WRITE_ERR
                                                 : stc_pkg::ASC_READ_ERR;
                     end
                     state_in = stc_pkg::BK_IDLE;
                  end
                  default: begin
                     beat.status = job_ff.status;
                     key_in      = job_ff.key;
                     code_in     = job_ff.code;
                     state_in    = stc_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         default: state_in = stc_pkg::BK_IDLE;
      endcase

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = beat;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stc_pkg::BK_IDLE;
         key_ff       <= stc_pkg::KEY_NONE;
         code_ff      <= stc_pkg::ASC_NONE;
         pend_ff      <= 1'b0;
         pend_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         code_ff      <= code_in;
         pend_ff      <= pend_in;
         pend_wr_ff   <= pend_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/scsi_target_command_engine.sv =====
// Channel   Ports                                  Beat
// req       req_push, req_full, req_data           one command or transfer report
// rsp       rsp_empty, rsp_pop, rsp_data           one data byte, request or completion
// csr       csr_write_en, csr_write_data           disk size in blocks
//
// A request is classified in the cycle it is pushed and lands in a two-entry
// job queue. The back end takes a queued job once it is idle and the queue's
// registered count shows it, then emits one beat per cycle while rsp is
// drained. A transfer report with nothing outstanding gives no beat. Reset
// clears the queue, sense and pending transfer state and the output register;
// a stalled rsp holds the back end while the front keeps filling the queue
// until req_full.
module scsi_target_command_engine #(
   parameter int unsigned MAX_BLOCKS = stc_pkg::MAX_BLOCKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  stc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output stc_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [31:0]      csr_write_data
);

   logic [31:0]      disk_sectors_ff, disk_sectors_in;
   stc_pkg::job_type front_job;
   stc_pkg::job_type back_job;
   logic             job_empty;
   logic             job_pop;

   // hold the disk size until software rewrites it
   assign disk_sectors_in = csr_write_en ? csr_write_data : disk_sectors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_sectors_ff <= 32'd0;
      end else begin
         disk_sectors_ff <= disk_sectors_in;
      end
   end

   // classify the beat: opcode decode, length clamp, range check
   stc_front #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .req          (req_data),
      .disk_sectors (disk_sectors_ff),
      .job          (front_job)
   );

   // decouple decode from result streaming
   stc_queue #(
      .DEPTH (stc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (job_pop),
      .pop_job  (back_job),
      .empty    (job_empty)
   );

   // execute: stream bytes, issue transfers, track sense and pending state
   stc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (back_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stc_pkg::*;

   // Input item kinds: a new descriptor or the report of a finished disk transfer.
   localparam logic OPN_COMMAND   = 1'b0;
   localparam logic OPN_XFER_DONE = 1'b1;

   localparam int unsigned XFER_MAX = MAX_BLOCKS_DEF;

   // Fixed sense layout: response code, additional length.
   localparam logic [7:0] SENSE_CODE_FIXED = 8'h70;
   localparam logic [7:0] SENSE_ADD_LEN    = 8'd10;
   localparam logic [7:0] MODE_DATA_LEN    = 8'h03;

   // Standard inquiry data as the target reports it.
   localparam logic [7:0] INQUIRY_DATA [36] = '{
      8'h00, 8'h00, 8'h01, 8'h01, 8'h1F, 8'h00, 8'h00, 8'h00,
      8'h4E, 8'h45, 8'h43, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h50, 8'h43, 8'h2D, 8'h39, 8'h38, 8'h20, 8'h48, 8'h44,
      8'h44, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h31, 8'h2E, 8'h30, 8'h30
   };

   // Commands that only report status or stream a response.
   localparam logic [7:0] STATUS_OPS [11] = '{
      OP_TEST_UNIT_READY, OP_REZERO, OP_REQUEST_SENSE, OP_FORMAT, OP_SEEK6,
      OP_INQUIRY, OP_MODE_SELECT, OP_MODE_SENSE, OP_START_STOP,
      OP_READ_CAPACITY, OP_SEEK10
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   scsi_target_command_engine DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Target state as the testbench tracks it, advanced at each accepted beat.
   logic [31:0] disk_blocks  = '0;
   logic [3:0]  held_key     = '0;
   logic [7:0]  held_asc     = '0;
   logic        xfer_open    = 1'b0;
   logic        xfer_open_wr = 1'b0;

   req_type     cmd_backlog [$];   // items waiting for the driver
   rsp_type     beats_due [$];     // responses the target still owes, oldest first
   int unsigned mismatches = 0;

   // ---------------------------------------------------------------------------
   // Response prediction
   // ---------------------------------------------------------------------------
   function automatic void add_beat(input logic [1:0] kind, input logic [7:0] data,
                                    input logic status, input logic [31:0] lba,
                                    input logic [4:0] blocks, input logic wr);
      rsp_type b;
      b.kind            = kind;
      b.data_byte       = data;
      b.status          = status;
      b.transfer_lba    = lba;
      b.transfer_blocks = blocks;
      b.transfer_write  = wr;
      b.last            = 1'b0;
      beats_due.push_back(b);
   endfunction

   // GOOD clears the sense, CHECK CONDITION latches the one it names.
   function automatic void finish_good();
      held_key = KEY_NONE;
      held_asc = ASC_NONE;
      add_beat(KIND_DONE, 8'h00, 1'b0, '0, '0, 1'b0);
   endfunction

   function automatic void finish_check(input logic [3:0] key, input logic [7:0] asc);
      held_key = key;
      held_asc = asc;
      add_beat(KIND_DONE, 8'h00, 1'b1, '0, '0, 1'b0);
   endfunction

   // Clamp the count, then range-check in 33 bits so lba + count cannot wrap.
   function automatic void request_io(input logic [31:0] lba, input int unsigned cnt,
                                      input logic wr);
      logic [32:0] top;
      if (disk_blocks == 0) begin
         finish_check(KEY_NOT_READY, ASC_NO_MEDIUM);
      end else if (cnt == 0) begin
         finish_good();
      end else begin
         if (cnt > XFER_MAX) cnt = XFER_MAX;
         top = {1'b0, lba} + cnt;
         if (lba >= disk_blocks || top > {1'b0, disk_blocks}) begin
            finish_check(KEY_ILLEGAL, ASC_LBA_RANGE);
         end else begin
            xfer_open    = 1'b1;
            xfer_open_wr = wr;
            add_beat(KIND_XFER, 8'h00, 1'b0, lba, cnt[4:0], wr);
         end
      end
   endfunction

   function automatic void predict_response(input req_type r);
      logic [7:0]  resp [36];
      logic [31:0] lba;
      int unsigned len;
      int unsigned alloc;
      int          first;
      rsp_type     tail;
      first = beats_due.size();
      len   = 0;
      alloc = r.cdb_byte4;
      for (int i = 0; i < 36; i++) resp[i] = 8'h00;

      if (r.operation == OPN_XFER_DONE) begin
         // A report with nothing outstanding is dropped without a beat.
         if (xfer_open) begin
            xfer_open = 1'b0;
            if (r.transfer_ok) finish_good();
            else finish_check(KEY_NOT_READY, xfer_open_wr ? ASC_WRITE_ERR : ASC_READ_ERR);
         end
      end else begin
         // A new descriptor silently abandons any transfer still open.
         xfer_open = 1'b0;
         case (r.cdb_opcode)
            OP_TEST_UNIT_READY: begin
               if (disk_blocks != 0) finish_good();
               else finish_check(KEY_NOT_READY, ASC_NO_MEDIUM);
            end
            OP_REZERO, OP_FORMAT, OP_SEEK6, OP_MODE_SELECT, OP_START_STOP, OP_SEEK10: begin
               finish_good();
            end
            OP_REQUEST_SENSE: begin
               len       = LEN_SENSE;
               resp[0]   = SENSE_CODE_FIXED;
               resp[2]   = {4'h0, held_key};
               resp[7]   = SENSE_ADD_LEN;
               resp[12]  = held_asc;
            end
            OP_INQUIRY: begin
               len = LEN_INQUIRY;
               for (int i = 0; i < 36; i++) resp[i] = INQUIRY_DATA[i];
            end
            OP_MODE_SENSE: begin
               len     = LEN_MODE;
               resp[0] = MODE_DATA_LEN;
            end
            OP_READ_CAPACITY: begin
               if (disk_blocks == 0) begin
                  finish_check(KEY_NOT_READY, ASC_NO_MEDIUM);
               end else begin
                  // Capacity ignores the allocation length.
                  len     = LEN_CAPACITY;
                  alloc   = 0;
                  lba     = disk_blocks - 1;
                  resp[0] = lba[31:24];
                  resp[1] = lba[23:16];
                  resp[2] = lba[15:8];
                  resp[3] = lba[7:0];
                  resp[6] = 8'h02;
               end
            end
            OP_READ6, OP_WRITE6: begin
               lba = {11'd0, r.cdb_byte1[4:0], r.cdb_byte2, r.cdb_byte3};
               request_io(lba, (r.cdb_byte4 == 0) ? 256 : r.cdb_byte4,
                          r.cdb_opcode == OP_WRITE6);
            end
            OP_READ10, OP_WRITE10: begin
               lba = {r.cdb_byte2, r.cdb_byte3, r.cdb_byte4, r.cdb_byte5};
               request_io(lba, {r.cdb_byte7, r.cdb_byte8}, r.cdb_opcode == OP_WRITE10);
            end
            default: finish_check(KEY_ILLEGAL, ASC_BAD_OP);
         endcase
         // Stream the response cut to the allocation length, then GOOD.
         if (len != 0) begin
            if (alloc == 0 || alloc > len) alloc = len;
            for (int i = 0; i < alloc; i++) add_beat(KIND_DATA, resp[i], 1'b0, '0, '0, 1'b0);
            finish_good();
         end
      end

      // Flag the final beat caused by this item.
      if (beats_due.size() > first) begin
         tail      = beats_due.pop_back();
         tail.last = 1'b1;
         beats_due.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Item builders
   // ---------------------------------------------------------------------------
   function automatic req_type scramble();
      req_type r;
      r.operation   = $urandom_range(0, 1);
      r.transfer_ok = $urandom_range(0, 1);
      r.cdb_opcode  = $urandom;
      r.cdb_byte1   = $urandom;
      r.cdb_byte2   = $urandom;
      r.cdb_byte3   = $urandom;
      r.cdb_byte4   = $urandom;
      r.cdb_byte5   = $urandom;
      r.cdb_byte7   = $urandom;
      r.cdb_byte8   = $urandom;
      return r;
   endfunction

   function automatic req_type cmd(input logic [7:0] op, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input logic [7:0] b4, input logic [7:0] b5,
                                   input logic [7:0] b7, input logic [7:0] b8);
      req_type r;
      r.operation   = OPN_COMMAND;
      r.transfer_ok = 1'b0;
      r.cdb_opcode  = op;
      r.cdb_byte1   = b1;
      r.cdb_byte2   = b2;
      r.cdb_byte3   = b3;
      r.cdb_byte4   = b4;
      r.cdb_byte5   = b5;
      r.cdb_byte7   = b7;
      r.cdb_byte8   = b8;
      return r;
   endfunction

   function automatic req_type xfer_report(input logic ok);
      req_type r;
      r             = scramble();
      r.operation   = OPN_XFER_DONE;
      r.transfer_ok = ok;
      return r;
   endfunction

   // Read or write aimed mostly at the interesting corners of the current disk.
   function automatic req_type rw_cmd(input logic wr, input logic long_form);
      req_type     r;
      logic [31:0] lba;
      logic [15:0] cnt;
      r           = scramble();
      r.operation = OPN_COMMAND;
      case ($urandom_range(0, 3))
         0:       lba = $urandom_range(0, 40);
         1:       lba = disk_blocks - $urandom_range(0, 20);
         2:       lba = disk_blocks + $urandom_range(0, 3);
         default: lba = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       cnt = 16'd0;
         1, 2, 3: cnt = $urandom_range(1, XFER_MAX);
         default: cnt = $urandom;
      endcase
      if (long_form) begin
         r.cdb_opcode = wr ? OP_WRITE10 : OP_READ10;
         {r.cdb_byte2, r.cdb_byte3, r.cdb_byte4, r.cdb_byte5} = lba;
         {r.cdb_byte7, r.cdb_byte8} = cnt;
      end else begin
         r.cdb_opcode     = wr ? OP_WRITE6 : OP_READ6;
         r.cdb_byte1[4:0] = lba[20:16];
         r.cdb_byte2      = lba[15:8];
         r.cdb_byte3      = lba[7:0];
         r.cdb_byte4      = cnt[7:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offer backlog items in bursts, predict at each accepted beat
   // ---------------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push   <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_push && !req_full) predict_response(req_data);
         if (req_push && req_full) begin
            // hold the beat until the target takes it
         end else if (gap_left != 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            req_data <= cmd_backlog.pop_front();
            req_push <= 1'b1;
            // At the end of a burst pick the next gap; a quarter of bursts run on.
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check each popped beat, stall on a pattern of its own
   // ---------------------------------------------------------------------------
   int unsigned beats_seen     = 0;
   int unsigned hold_cycles    = 0;
   logic        long_hold_done = 1'b0;
   int unsigned pop_mode       = 0;
   int unsigned mode_left      = 0;
   logic [1:0]  pop_tick       = '0;

   task automatic compare_beat(input rsp_type got);
      rsp_type want;
      if (beats_due.size() == 0) begin
         $error("unexpected beat: kind %0d data %02h status %0d", got.kind, got.data_byte,
                got.status);
         mismatches++;
      end else begin
         want = beats_due.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.transfer_lba !== want.transfer_lba) begin
            $error("transfer_lba: expected %08h, got %08h", want.transfer_lba,
                   got.transfer_lba);
            mismatches++;
         end
         if (got.transfer_blocks !== want.transfer_blocks) begin
            $error("transfer_blocks: expected %0d, got %0d", want.transfer_blocks,
                   got.transfer_blocks);
            mismatches++;
         end
         if (got.transfer_write !== want.transfer_write) begin
            $error("transfer_write: expected %0d, got %0d", want.transfer_write,
                   got.transfer_write);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            compare_beat(rsp_data);
            beats_seen++;
         end
         pop_tick <= pop_tick + 2'd1;
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else if (!long_hold_done && beats_seen > 50 && cmd_backlog.size() > 20) begin
            // Hold off once for a long stretch so the job queue fills and req_full rises.
            long_hold_done = 1'b1;
            hold_cycles    = 400;
            rsp_pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pop_mode  = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 80);
            end else begin
               mode_left--;
            end
            case (pop_mode)
               0:       rsp_pop <= 1'b1;                          // drain flat out
               1:       rsp_pop <= ($urandom_range(0, 2) == 0);   // sparse random pops
               default: rsp_pop <= (pop_tick == 2'd3);            // one pop in four
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Wait until every offered item is in and every owed beat is out.
   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_push || beats_due.size() != 0);
   endtask

   // Reconfigure only with the target idle; allow for a dropped report still in flight.
   task automatic set_disk(input logic [31:0] blocks);
      wait_idle();
      repeat (10) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= blocks;
      disk_blocks    = blocks;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input int unsigned items);
      int unsigned made;
      int unsigned roll;
      req_type     r;
      made = 0;
      while (made < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            // Mostly read/write followed by its report; sometimes the report never comes.
            cmd_backlog.push_back(rw_cmd($urandom_range(0, 1), $urandom_range(0, 1)));
            made++;
            if ($urandom_range(0, 9) != 0) begin
               cmd_backlog.push_back(xfer_report($urandom_range(0, 3) != 0));
               made++;
            end
         end else if (roll < 82) begin
            r            = scramble();
            r.operation  = OPN_COMMAND;
            r.cdb_opcode = STATUS_OPS[$urandom_range(0, 10)];
            case ($urandom_range(0, 2))
               0:       r.cdb_byte4 = 8'd0;
               1:       r.cdb_byte4 = $urandom_range(1, 40);
               default: r.cdb_byte4 = $urandom;
            endcase
            cmd_backlog.push_back(r);
            made++;
         end else if (roll < 92) begin
            r           = scramble();
            r.operation = OPN_COMMAND;
            cmd_backlog.push_back(r);
            made++;
         end else begin
            // Stray report: usually ignored, so it does not count.
            cmd_backlog.push_back(xfer_report($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No medium: every media access must fail with not ready.
      set_disk(32'd0);
      cmd_backlog.push_back(cmd(OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_REQUEST_SENSE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_READ_CAPACITY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_READ6, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_WRITE10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01));
      cmd_backlog.push_back(cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      cmd_backlog.push_back(cmd(OP_REQUEST_SENSE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(xfer_report(1'b1));

      // Medium just past the six-byte LBA reach.
      set_disk(32'h0020_0010);
      cmd_backlog.push_back(cmd(OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_MODE_SENSE, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_READ_CAPACITY, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00,
                                8'h00, 8'h00));
      // Six-byte read at the top LBA with count 0 meaning 256, clamped.
      cmd_backlog.push_back(cmd(OP_READ6, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(xfer_report(1'b0));
      cmd_backlog.push_back(cmd(OP_REQUEST_SENSE, 8'h00, 8'h00, 8'h00, 8'd13, 8'h00,
                                8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_WRITE10, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00,
                                8'hFF, 8'hFF));
      cmd_backlog.push_back(xfer_report(1'b0));
      // Open a write, then abandon it with a zero-length read.
      cmd_backlog.push_back(cmd(OP_WRITE6, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_READ10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      cmd_backlog.push_back(cmd(OP_READ10, 8'h00, 8'h00, 8'h20, 8'h00, 8'h10, 8'h00, 8'h01));
      cmd_backlog.push_back(cmd(OP_READ10, 8'h00, 8'h00, 8'h20, 8'h00, 8'h0F, 8'h00, 8'h02));
      cmd_backlog.push_back(cmd(OP_SEEK10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      random_phase(60);

      // Largest disk: the range check must not wrap past 2**32.
      set_disk(32'hFFFF_FFFF);
      cmd_backlog.push_back(cmd(OP_READ10, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h10));
      cmd_backlog.push_back(cmd(OP_WRITE10, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hEF, 8'h00, 8'h10));
      cmd_backlog.push_back(xfer_report(1'b1));
      random_phase(60);

      set_disk(32'd1);
      random_phase(55);
      set_disk(32'd0);
      random_phase(40);
      set_disk($urandom);
      random_phase(60);
      set_disk(32'h0000_0100);
      random_phase(60);

      // Drain, then give stray beats a chance to show up.
      wait_idle();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && beats_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
